// ===== design/crcfa_pkg.sv =====
package crcfa_pkg;

    // CRC-15 generator and seed
    localparam logic [14:0] CRC_POLY = 15'h4599;
    localparam logic [14:0] CRC_SEED = 15'd16;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // One classified word waiting in the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
        logic [7:0] chk_hi;
        logic [7:0] chk_lo;
    } crcfa_entry_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } crcfa_qstat_t;

    // Fold one byte into the remainder, eight bit steps
    function automatic logic [14:0] crc_byte(input logic [14:0] rem, input logic [7:0] b);
        logic [14:0] r;
        r = rem ^ {b, 7'd0};
        for (int k = 0; k < 8; k++) begin
            if (r[14]) begin
                r = {r[13:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[13:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ===== design/crcfa_front.sv =====
module crcfa_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // data_byte
    input  logic                   s_tlast,   // frame_end
    input  crcfa_pkg::crcfa_qstat_t q_stat,
    output logic                   push,
    output crcfa_pkg::crcfa_entry_t push_entry
);

    logic [14:0] crc_reg;
    logic [14:0] crc_next;
    logic [14:0] crc_upd;

    // Accept a word whenever the queue has room
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    // Fold the byte in and build the check word
    always_comb begin
        crc_upd                 = crcfa_pkg::crc_byte(crc_reg, s_tdata);
        push_entry.data_byte    = s_tdata;
        push_entry.frame_end    = s_tlast;
        push_entry.chk_hi       = crc_upd[14:7];
        push_entry.chk_lo       = {crc_upd[6:0], 1'b0};
        crc_next                = crc_reg;
        if (push) begin
            crc_next = s_tlast ? crcfa_pkg::CRC_SEED : crc_upd;
        end
    end

    // Hold the running remainder, reload the seed at frame end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= crcfa_pkg::CRC_SEED;
        end else begin
            crc_reg <= crc_next;
        end
    end

endmodule

// ===== design/crcfa_queue.sv =====
module crcfa_queue #(
    parameter int QUEUE_DEPTH = crcfa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  crcfa_pkg::crcfa_entry_t push_entry,
    input  logic                    pop,
    output crcfa_pkg::crcfa_entry_t head,
    output crcfa_pkg::crcfa_qstat_t q_stat
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

    crcfa_pkg::crcfa_entry_t slot_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign q_stat.full  = (count_reg == CntFull);
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/crcfa_back.sv =====
module crcfa_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  crcfa_pkg::crcfa_entry_t head,
    input  crcfa_pkg::crcfa_qstat_t q_stat,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,   // out_byte
    output logic                    m_tuser,   // is_check
    output logic                    m_tlast    // run_last
);

    typedef enum logic [2:0] {
        PH_DATA = 3'b001,
        PH_HI   = 3'b010,
        PH_LO   = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       chk_reg, chk_next;
    logic       last_reg, last_next;
    logic       load;

    // Load a new word when the output register is free or being drained
    assign load = !q_stat.empty && (!valid_reg || m_tready);

    always_comb begin
        phase_next = phase_reg;
        byte_next  = byte_reg;
        chk_next   = chk_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        valid_next = valid_reg && !m_tready;
        if (load) begin
            valid_next = 1'b1;
            unique case (phase_reg)
                PH_DATA: begin
                    byte_next = head.data_byte;
                    chk_next  = 1'b0;
                    last_next = !head.frame_end;
                    if (head.frame_end) begin
                        phase_next = PH_HI;
                    end else begin
                        pop = 1'b1;
                    end
                end
                PH_HI: begin
                    byte_next  = head.chk_hi;
                    chk_next   = 1'b1;
                    last_next  = 1'b0;
                    phase_next = PH_LO;
                end
                PH_LO: begin
                    byte_next  = head.chk_lo;
                    chk_next   = 1'b1;
                    last_next  = 1'b1;
                    phase_next = PH_DATA;
                    pop        = 1'b1;
                end
                default: begin
                    phase_next = PH_DATA;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DATA;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the output payload
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        chk_reg  <= chk_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = chk_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== design/crc15_frame_appender_core.sv =====
// Channel  Dir  tdata     tuser     tlast     Words
// s_       in   data_byte -         frame_end one per input item
// m_       out  out_byte  is_check  run_last  one per byte, three at frame end
//
// The front folds one byte per cycle into the CRC-15 remainder (eight bit steps)
// and queues it while the queue has room; the back emits one word per cycle from
// the output register while the sink is ready; a frame end yields three words.
// Data passes from input to output through the queue slot and output register.
// Reset clears queue, phase and output valid; the remainder reloads to 16.
// Either side may stall; the queue absorbs the check bytes and output stalls.
module crc15_frame_appender_core #(
    parameter int QUEUE_DEPTH = crcfa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tlast,   // frame_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tuser,   // is_check
    output logic       m_tlast    // run_last
);

    crcfa_pkg::crcfa_entry_t push_entry;
    crcfa_pkg::crcfa_entry_t head;
    crcfa_pkg::crcfa_qstat_t q_stat;
    logic                    push;
    logic                    pop;

    crcfa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    crcfa_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    crcfa_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
